@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/cmwt_pkg.sv @@
// ---------------------------------------------------------------------------
// cmwt_pkg
// shared types and constants of the channel multiplicity window trigger
// ---------------------------------------------------------------------------
package cmwt_pkg;

  localparam int NUM_CHANNELS_DEF = 1024;
  localparam int WINDOW_DEPTH_DEF = 256;

  localparam int TIME_W   = 64;
  localparam int HIT_CH_W = 10;
  localparam int WIN_W    = 32;
  localparam int MINCH_W  = 11;

  localparam logic [1:0] REG_TRIGGER_WINDOW = 2'd0;
  localparam logic [1:0] REG_DATA_WINDOW    = 2'd1;
  localparam logic [1:0] REG_MIN_CHANNELS   = 2'd2;

  localparam logic [WIN_W-1:0]   TRIGGER_WINDOW_RST = 32'd400;
  localparam logic [WIN_W-1:0]   DATA_WINDOW_RST    = 32'd10000;
  localparam logic [MINCH_W-1:0] MIN_CHANNELS_RST   = 11'd3;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LOOP_RD,
    S_LOOP_CMP,
    S_POP_WR,
    S_PUSH,
    S_PUSH_WR,
    S_FINAL_RD,
    S_FINAL_CMP,
    S_CLR_RD,
    S_CLR_WR,
    S_POST,
    S_OUT
  } state_t;

endpackage

@@ rtl/core/channel_multiplicity_window_trigger_top.sv @@
// ---------------------------------------------------------------------------
// channel_multiplicity_window_trigger_top
// sliding window multiplicity trigger over time ordered detector hits
// ---------------------------------------------------------------------------
// channel | direction | handshake            | word
// hit     | in        | hit_valid, hit_stall | hit_time, hit_channel, last_hit
// res     | out       | res_valid, res_stall | window_left, window_right,
//         |           |                      | last_of_run, overflow_seen
// apb     | in        | psel, penable        | paddr, pwdata, prdata
//
// one hit at a time: an accept, the check that ends the loop, a pop per old
// entry, a push, the final test, a clear walk over each kept entry that then
// empties the window, a wrap up, then the result words one by one
// pops and pushes are read-modify-writes of the count table
// after reset the count table is zeroed entry by entry, hit_stall high
// hit_stall is high whenever a hit is in work or its results wait on res_stall
// ---------------------------------------------------------------------------
module channel_multiplicity_window_trigger_top
  import cmwt_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                hit_valid,
  output logic                hit_stall,
  input  logic [TIME_W-1:0]   hit_time,
  input  logic [HIT_CH_W-1:0] hit_channel,
  input  logic                last_hit,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [TIME_W-1:0]   window_left,
  output logic [TIME_W-1:0]   window_right,
  output logic                last_of_run,
  output logic                overflow_seen,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  `include "assert_macros.svh"

  localparam int AW   = $clog2(WINDOW_DEPTH);
  localparam int FW   = $clog2(WINDOW_DEPTH + 1);
  localparam int CW   = $clog2(NUM_CHANNELS);
  localparam int DCW  = $clog2(NUM_CHANNELS + 1);
  localparam int CNTW = FW;

  // configuration
  logic [WIN_W-1:0]   trigger_window;
  logic [WIN_W-1:0]   data_window;
  logic [MINCH_W-1:0] min_channels;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_window <= TRIGGER_WINDOW_RST;
      data_window    <= DATA_WINDOW_RST;
      min_channels   <= MIN_CHANNELS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TRIGGER_WINDOW: trigger_window <= pwdata;
        REG_DATA_WINDOW:    data_window    <= pwdata;
        REG_MIN_CHANNELS:   min_channels   <= pwdata[MINCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TRIGGER_WINDOW: prdata = trigger_window;
      REG_DATA_WINDOW:    prdata = data_window;
      REG_MIN_CHANNELS:   prdata = {{(32-MINCH_W){1'b0}}, min_channels};
      default:            prdata = '0;
    endcase
  end

  // state
  state_t state, state_next;

  logic [TIME_W-1:0]   cur_time;
  logic                cur_last;
  logic [CW-1:0]       cur_ch;
  logic [CW-1:0]       ch_in;

  logic [AW-1:0]       head;
  logic [FW-1:0]       fill;
  logic [DCW-1:0]      distinct;
  logic [TIME_W-1:0]   skip_until;
  logic                skip_active;
  logic                overflow;
  logic                final_clr;
  logic [AW-1:0]       ptr;
  logic [FW-1:0]       walk_left;
  logic [CW-1:0]       init_idx;

  logic [TIME_W-1:0]   res_left [2];
  logic [TIME_W-1:0]   res_right [2];
  logic [1:0]          res_n;
  logic                res_k;

  // memories
  logic [TIME_W-1:0]   fifo_time [WINDOW_DEPTH];
  logic [CW-1:0]       fifo_chan [WINDOW_DEPTH];
  logic [CNTW-1:0]     cnt_mem [NUM_CHANNELS];

  logic                fifo_we, fifo_re;
  logic [AW-1:0]       fifo_waddr, fifo_raddr;
  logic [TIME_W-1:0]   rd_time;
  logic [CW-1:0]       rd_ch;
  logic                cnt_we, cnt_re;
  logic [CW-1:0]       cnt_waddr, cnt_raddr;
  logic [CNTW-1:0]     cnt_wdata, cnt_rd;

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_time[fifo_waddr] <= cur_time;
      fifo_chan[fifo_waddr] <= cur_ch;
    end
    if (fifo_re) begin
      rd_time <= fifo_time[fifo_raddr];
      rd_ch   <= fifo_chan[fifo_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd <= cnt_mem[cnt_raddr];
    end
  end

  // channel reduction by reciprocal multiply, exact for 10 bit channels
  generate
    if (NUM_CHANNELS >= (1 << HIT_CH_W)) begin : g_no_reduce
      assign ch_in = CW'(hit_channel);
    end else begin : g_reduce
      localparam int RECIP = ((1 << 20) + NUM_CHANNELS - 1) / NUM_CHANNELS;
      logic [31:0] prod;
      logic [31:0] qn;
      assign prod  = 32'(hit_channel) * 32'(RECIP);
      assign qn    = 32'(prod[20 +: HIT_CH_W]) * 32'(NUM_CHANNELS);
      assign ch_in = CW'(hit_channel - HIT_CH_W'(qn));
    end
  endgenerate

  // helpers
  logic              accept, out_take;
  logic              skip_hit, cmp_far, can_fire, last_k, fifo_full;
  logic [TIME_W-1:0] age;
  logic [AW:0]       wr_sum;
  logic [AW-1:0]     head_inc, ptr_inc;

  assign accept    = hit_valid && !hit_stall;
  assign out_take  = res_valid && !res_stall;
  assign skip_hit  = skip_active && (hit_time < skip_until);
  assign age       = cur_time - rd_time;
  assign cmp_far   = age >= {{(TIME_W-WIN_W){1'b0}}, trigger_window};
  assign can_fire  = 32'(distinct) >= 32'(min_channels);
  assign fifo_full = fill == FW'(WINDOW_DEPTH);
  assign last_k    = {1'b0, res_k} == res_n - 2'd1;
  assign wr_sum    = (AW+1)'(head) + (AW+1)'(fill);
  assign fifo_waddr = (wr_sum >= (AW+1)'(WINDOW_DEPTH)) ?
                      AW'(wr_sum - (AW+1)'(WINDOW_DEPTH)) : AW'(wr_sum);
  assign head_inc  = (head == AW'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
  assign ptr_inc   = (ptr == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:      if (init_idx == CW'(NUM_CHANNELS - 1)) state_next = S_IDLE;
      S_IDLE:      if (accept) state_next = skip_hit ? S_POST : S_LOOP_RD;
      S_LOOP_RD:   state_next = (fill == '0) ? S_PUSH : S_LOOP_CMP;
      S_LOOP_CMP: begin
        if (!cmp_far) state_next = S_PUSH;
        else if (can_fire) state_next = S_CLR_RD;
        else state_next = S_POP_WR;
      end
      S_POP_WR:    state_next = S_LOOP_RD;
      S_PUSH: begin
        if (!fifo_full) state_next = S_PUSH_WR;
        else state_next = cur_last ? S_FINAL_RD : S_POST;
      end
      S_PUSH_WR:   state_next = cur_last ? S_FINAL_RD : S_POST;
      S_FINAL_RD:  state_next = (fill == '0) ? S_POST : S_FINAL_CMP;
      S_FINAL_CMP: state_next = S_POST;
      S_CLR_RD: begin
        if (walk_left != '0) state_next = S_CLR_WR;
        else if (final_clr) state_next = (res_n == '0) ? S_IDLE : S_OUT;
        else state_next = (cur_time < skip_until) ? S_POST : S_PUSH;
      end
      S_CLR_WR:    state_next = S_CLR_RD;
      S_POST: begin
        if (cur_last) state_next = S_CLR_RD;
        else state_next = (res_n == '0) ? S_IDLE : S_OUT;
      end
      S_OUT:       if (out_take && last_k) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // memory controls and port outputs
  always_comb begin
    fifo_we    = 1'b0;
    fifo_re    = 1'b0;
    fifo_raddr = head;
    cnt_we     = 1'b0;
    cnt_re     = 1'b0;
    cnt_waddr  = rd_ch;
    cnt_raddr  = rd_ch;
    cnt_wdata  = '0;
    hit_stall  = 1'b1;
    res_valid  = 1'b0;
    case (state)
      S_INIT: begin
        cnt_we    = 1'b1;
        cnt_waddr = init_idx;
      end
      S_IDLE:      hit_stall = 1'b0;
      S_LOOP_RD:   fifo_re = 1'b1;
      S_LOOP_CMP:  cnt_re = cmp_far && !can_fire;
      S_POP_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_rd - 1'b1;
      end
      S_PUSH: begin
        fifo_we   = !fifo_full;
        cnt_re    = !fifo_full;
        cnt_raddr = cur_ch;
      end
      S_PUSH_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = cur_ch;
        cnt_wdata = cnt_rd + 1'b1;
      end
      S_FINAL_RD:  fifo_re = 1'b1;
      S_CLR_RD: begin
        fifo_re    = walk_left != '0;
        fifo_raddr = ptr;
      end
      S_CLR_WR:    cnt_we = 1'b1;
      S_OUT:       res_valid = 1'b1;
      default: ;
    endcase
  end

  assign window_left   = res_left[res_k];
  assign window_right  = res_right[res_k];
  assign last_of_run   = last_k;
  assign overflow_seen = overflow;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      init_idx    <= '0;
      head        <= '0;
      fill        <= '0;
      distinct    <= '0;
      skip_until  <= '0;
      skip_active <= 1'b0;
      overflow    <= 1'b0;
      final_clr   <= 1'b0;
      ptr         <= '0;
      walk_left   <= '0;
      res_n       <= '0;
      res_k       <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_INIT: init_idx <= init_idx + 1'b1;
        S_IDLE: begin
          if (accept) begin
            res_n <= '0;
            res_k <= 1'b0;
            if (skip_active && !skip_hit) skip_active <= 1'b0;
          end
        end
        S_LOOP_CMP: begin
          if (cmp_far && can_fire) begin
            if (res_n != 2'd2) res_n <= res_n + 1'b1;
            skip_until  <= rd_time + {{(TIME_W-WIN_W){1'b0}}, data_window};
            skip_active <= 1'b1;
            final_clr   <= 1'b0;
            ptr         <= head;
            walk_left   <= fill;
          end
        end
        S_POP_WR: begin
          if (cnt_rd == CNTW'(1)) distinct <= distinct - 1'b1;
          head <= head_inc;
          fill <= fill - 1'b1;
        end
        S_PUSH: if (fifo_full) overflow <= 1'b1;
        S_PUSH_WR: begin
          if (cnt_rd == '0) distinct <= distinct + 1'b1;
          fill <= fill + 1'b1;
        end
        S_FINAL_CMP: if (can_fire && res_n != 2'd2) res_n <= res_n + 1'b1;
        S_CLR_RD: begin
          if (walk_left != '0) begin
            ptr       <= ptr_inc;
            walk_left <= walk_left - 1'b1;
          end else begin
            head     <= '0;
            fill     <= '0;
            distinct <= '0;
            if (final_clr) begin
              skip_until  <= '0;
              skip_active <= 1'b0;
            end else if (!(cur_time < skip_until)) begin
              skip_active <= 1'b0;
            end
          end
        end
        S_POST: begin
          if (cur_last) begin
            final_clr <= 1'b1;
            ptr       <= head;
            walk_left <= fill;
          end
        end
        S_OUT: if (out_take && !last_k) res_k <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_time <= hit_time;
      cur_ch   <= ch_in;
      cur_last <= last_hit;
    end
    if ((state == S_LOOP_CMP && cmp_far && can_fire) ||
        (state == S_FINAL_CMP && can_fire)) begin
      if (res_n != 2'd2) begin
        res_left[res_n[0]]  <= rd_time - {{(TIME_W-WIN_W){1'b0}}, data_window};
        res_right[res_n[0]] <= rd_time + {{(TIME_W-WIN_W){1'b0}}, data_window};
      end
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, clk, rst, fill <= FW'(WINDOW_DEPTH), "window fill beyond depth")
  `ASSERT_ALWAYS(a_distinct_le_fill, clk, rst, 32'(distinct) <= 32'(fill), "distinct exceeds fill")
  `ASSERT_NEXT(a_clear_empties, clk, rst, state == S_CLR_RD && walk_left == '0, fill == '0 && distinct == '0, "window not empty after clear")
  `ASSERT_NEXT(a_skip_to_post, clk, rst, accept && skip_hit, state == S_POST, "skipped hit not dropped")

endmodule
